// ----- sv/kmd_pkg.sv -----
// Shared types, register codes and the per-key debounce update for the key matrix debouncer.
package kmd_pkg;

  localparam int unsigned ROWS   = 8;
  localparam int unsigned CFG_AW = 5;
  localparam int unsigned CFG_DW = 32;

  localparam logic [7:0] THRESHOLD_RESET = 8'd4;

  // Configuration register indexes, taken from paddr[4:2].
  typedef enum logic [2:0] {
    REG_THRESHOLD = 3'd0,
    REG_RELOAD    = 3'd1,
    REG_A_COL     = 3'd2,
    REG_A_ROW     = 3'd3,
    REG_B_COL     = 3'd4,
    REG_B_ROW     = 3'd5
  } kmd_reg_e;

  typedef struct packed {
    logic [7:0] threshold;
    logic [7:0] reload;
    logic [2:0] a_col;
    logic [2:0] a_row;
    logic [2:0] b_col;
    logic [2:0] b_row;
  } kmd_cfg_t;

  // Debounce state of one key.
  typedef struct packed {
    logic [7:0] count;
    logic       last;
    logic       stable;
  } kmd_cell_t;

  typedef kmd_cell_t [ROWS-1:0] kmd_row_t;

  typedef struct packed {
    logic [2:0] column;
    logic [7:0] stable_rows;
    logic       restore_stable;
    logic       combo_active;
    logic       combo_edge;
  } kmd_result_t;

  // The increment is one bit wider than the counter, so it never wraps.
  function automatic kmd_cell_t deb_update(kmd_cell_t c, logic reading,
                                           logic [7:0] thr, logic [7:0] reload);
    kmd_cell_t  n;
    logic [8:0] inc;
    n   = c;
    inc = {1'b0, c.count} + 9'd1;
    if (reading == c.last) begin
      if (inc >= {1'b0, thr}) begin
        n.stable = reading;
        n.count  = thr;
      end else begin
        n.count = inc[7:0];
      end
    end else begin
      n.count = reload;
    end
    n.last = reading;
    return n;
  endfunction

endpackage

// ----- sv/kmd_ram.sv -----
// Simple synchronous RAM with one write port and one registered read port.
module kmd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 8
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read-first: a read and a write to the same entry return the old data.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- sv/kmd_regs.sv -----
// APB configuration registers of the key matrix debouncer.
module kmd_regs
  import kmd_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready,
  output kmd_cfg_t          cfg_o
);

  kmd_cfg_t   cfg_q, cfg_d;
  logic [2:0] idx;
  logic       wr;

  assign idx    = paddr[4:2];
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (wr) begin
      case (idx)
        REG_THRESHOLD: cfg_d.threshold = pwdata[7:0];
        REG_RELOAD:    cfg_d.reload    = pwdata[7:0];
        REG_A_COL:     cfg_d.a_col     = pwdata[2:0];
        REG_A_ROW:     cfg_d.a_row     = pwdata[2:0];
        REG_B_COL:     cfg_d.b_col     = pwdata[2:0];
        REG_B_ROW:     cfg_d.b_row     = pwdata[2:0];
        default:       cfg_d           = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_THRESHOLD: prdata = CFG_DW'(cfg_q.threshold);
      REG_RELOAD:    prdata = CFG_DW'(cfg_q.reload);
      REG_A_COL:     prdata = CFG_DW'(cfg_q.a_col);
      REG_A_ROW:     prdata = CFG_DW'(cfg_q.a_row);
      REG_B_COL:     prdata = CFG_DW'(cfg_q.b_col);
      REG_B_ROW:     prdata = CFG_DW'(cfg_q.b_row);
      default:       prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{threshold: THRESHOLD_RESET, reload: 8'd0, a_col: 3'd0, a_row: 3'd0,
                 b_col: 3'd0, b_row: 3'd0};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- sv/kmd_core.sv -----
// Debounce datapath: key state memories, read-modify-write stage and combo detection.
module kmd_core
  import kmd_pkg::*;
#(
  parameter int unsigned NUM_COLUMNS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  kmd_cfg_t    cfg_i,
  input  logic        acc_i,
  input  logic [2:0]  column_i,
  input  logic [7:0]  row_bits_i,
  input  logic        restore_pressed_i,
  input  logic        adv_i,
  output logic        s1_valid_o,
  output kmd_result_t result_o
);

  localparam int unsigned AW     = (NUM_COLUMNS > 1) ? $clog2(NUM_COLUMNS) : 1;
  localparam int unsigned VDEPTH = 2 ** AW;
  localparam int unsigned RW     = $bits(kmd_row_t);
  localparam logic [31:0] NCOL   = 32'(NUM_COLUMNS);
  localparam logic [31:0] LAST   = 32'(NUM_COLUMNS - 1);

  logic              s1_valid_q;
  logic [2:0]        s1_col_q;
  logic [7:0]        s1_bits_q;
  logic              s1_restore_q;

  logic              key_fwd_q, key_vld_q;
  kmd_row_t          key_fwd_row_q;
  logic              a_fwd_q, a_vld_q, b_fwd_q, b_vld_q;
  logic [ROWS-1:0]   a_fwd_bits_q, b_fwd_bits_q;

  logic [VDEPTH-1:0] row_valid_q;
  kmd_cell_t         restore_q;
  logic              prev_combo_q;

  logic [AW-1:0]     key_raddr, a_raddr, b_raddr, wr_addr;
  logic [RW-1:0]     key_rdata;
  logic [ROWS-1:0]   a_rdata, b_rdata;

  kmd_row_t          key_row, new_row;
  logic [ROWS-1:0]   new_stable, a_row, b_row;
  kmd_cell_t         restore_new;
  logic              col_in_range, a_in_range, b_in_range, last_col;
  logic              a_bit, b_bit, active, edge_det, wr_en;

  assign key_raddr = AW'(column_i);
  assign a_raddr   = AW'(cfg_i.a_col);
  assign b_raddr   = AW'(cfg_i.b_col);
  assign wr_addr   = AW'(s1_col_q);

  kmd_ram #(.WIDTH(RW), .DEPTH(NUM_COLUMNS)) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_addr),
    .wdata_i (new_row),
    .re_i    (acc_i),
    .raddr_i (key_raddr),
    .rdata_o (key_rdata)
  );

  // Two copies of the stable bits give the two combo keys a read port each.
  kmd_ram #(.WIDTH(ROWS), .DEPTH(NUM_COLUMNS)) u_stable_a_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_addr),
    .wdata_i (new_stable),
    .re_i    (acc_i),
    .raddr_i (a_raddr),
    .rdata_o (a_rdata)
  );

  kmd_ram #(.WIDTH(ROWS), .DEPTH(NUM_COLUMNS)) u_stable_b_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_addr),
    .wdata_i (new_stable),
    .re_i    (acc_i),
    .raddr_i (b_raddr),
    .rdata_o (b_rdata)
  );

  always_comb begin
    col_in_range = {29'd0, s1_col_q} < NCOL;
    a_in_range   = {29'd0, cfg_i.a_col} < NCOL;
    b_in_range   = {29'd0, cfg_i.b_col} < NCOL;
    last_col     = {29'd0, s1_col_q} == LAST;

    // A row never written since reset reads as all zero.
    if (key_fwd_q) begin
      key_row = key_fwd_row_q;
    end else if (key_vld_q) begin
      key_row = kmd_row_t'(key_rdata);
    end else begin
      key_row = '0;
    end

    for (int r = 0; r < ROWS; r++) begin
      new_row[r]    = deb_update(key_row[r], s1_bits_q[r], cfg_i.threshold, cfg_i.reload);
      new_stable[r] = new_row[r].stable;
    end

    restore_new = deb_update(restore_q, s1_restore_q, cfg_i.threshold, cfg_i.reload);

    if (col_in_range && (cfg_i.a_col == s1_col_q)) begin
      a_row = new_stable;
    end else if (a_fwd_q) begin
      a_row = a_fwd_bits_q;
    end else if (a_vld_q) begin
      a_row = a_rdata;
    end else begin
      a_row = '0;
    end

    if (col_in_range && (cfg_i.b_col == s1_col_q)) begin
      b_row = new_stable;
    end else if (b_fwd_q) begin
      b_row = b_fwd_bits_q;
    end else if (b_vld_q) begin
      b_row = b_rdata;
    end else begin
      b_row = '0;
    end

    a_bit    = a_in_range && a_row[cfg_i.a_row];
    b_bit    = b_in_range && b_row[cfg_i.b_row];
    active   = a_bit && b_bit;
    edge_det = last_col && active && !prev_combo_q;
    wr_en    = adv_i && s1_valid_q && col_in_range;
  end

  always_comb begin
    result_o.column         = s1_col_q;
    result_o.stable_rows    = col_in_range ? new_stable : '0;
    result_o.restore_stable = restore_new.stable;
    result_o.combo_active   = active;
    result_o.combo_edge     = edge_det;
  end

  assign s1_valid_o = s1_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q   <= 1'b0;
      key_fwd_q    <= 1'b0;
      key_vld_q    <= 1'b0;
      a_fwd_q      <= 1'b0;
      a_vld_q      <= 1'b0;
      b_fwd_q      <= 1'b0;
      b_vld_q      <= 1'b0;
      row_valid_q  <= '0;
      restore_q    <= '0;
      prev_combo_q <= 1'b0;
    end else begin
      if (acc_i) begin
        s1_valid_q <= 1'b1;
        // The row leaving the stage this cycle is not in the memory yet.
        key_fwd_q  <= wr_en && (wr_addr == key_raddr);
        a_fwd_q    <= wr_en && (wr_addr == a_raddr);
        b_fwd_q    <= wr_en && (wr_addr == b_raddr);
        key_vld_q  <= row_valid_q[key_raddr];
        a_vld_q    <= row_valid_q[a_raddr];
        b_vld_q    <= row_valid_q[b_raddr];
      end else if (adv_i) begin
        s1_valid_q <= 1'b0;
      end
      if (wr_en) begin
        row_valid_q[wr_addr] <= 1'b1;
      end
      if (adv_i && s1_valid_q) begin
        restore_q <= restore_new;
        if (last_col) begin
          prev_combo_q <= active;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_i) begin
      s1_col_q      <= column_i;
      s1_bits_q     <= row_bits_i;
      s1_restore_q  <= restore_pressed_i;
      key_fwd_row_q <= new_row;
      a_fwd_bits_q  <= new_stable;
      b_fwd_bits_q  <= new_stable;
    end
  end

  a_edge_needs_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && result_o.combo_edge |-> result_o.combo_active)
    else $error("combo edge reported without an active combo");

  a_written_row_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |=> row_valid_q[$past(wr_addr)])
    else $error("written row not marked valid");

  a_prev_combo_tracks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv_i && s1_valid_q && last_col |=> prev_combo_q == $past(active))
    else $error("previous combo not taken from the last column");

endmodule

// ----- sv/key_matrix_debouncer.sv -----
// Top level of the key matrix debouncer: input and output handshakes around the debounce core.
//
// Each input transfer carries one scanned column: column_i, its eight raw row bits and the
// raw reading of the restore key. Every key of that column and the restore key advance their
// counter-based debouncers, and one output transfer returns the column's stable bits, the
// restore key's stable state, whether both combo keys are held, and the combo's rising edge,
// which is only reported on the last column of a scan.
// The key state lives in a memory of one row per column. An accepted item reads its row when
// accepted, is updated in the update stage and written back when that stage advances, when its
// result also enters the output register. A new item is taken every cycle while in_stall_o is
// low; back-to-back items on one column are served by forwarding the row still being written.
// Reset clears per-row valid bits at once, so every key starts at zero without a clearing pass;
// the registers return to threshold 4, reload 0 and both combo keys at column 0, row 0.
// When the receiver stalls, the result holds in the output register and one more item can
// still be taken into the update stage; after that in_stall_o rises until the output drains.
// Configuration must be written over the APB port only while no item is in flight; not enforced.
module key_matrix_debouncer
  import kmd_pkg::*;
#(
  parameter int unsigned NUM_COLUMNS = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [2:0]        column_i,
  input  logic [7:0]        row_bits_i,
  input  logic              restore_pressed_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [2:0]        column_out_o,
  output logic [7:0]        stable_rows_o,
  output logic              restore_stable_o,
  output logic              combo_active_o,
  output logic              combo_edge_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready
);

  kmd_cfg_t    cfg;
  kmd_result_t stage_res;
  kmd_result_t out_q;
  logic        out_valid_q;
  logic        s1_valid;
  logic        acc, adv;

  kmd_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // The update stage moves on whenever the output register is empty or being emptied.
  assign adv        = s1_valid && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid && !adv;
  assign acc        = in_valid_i && !in_stall_o;

  kmd_core #(.NUM_COLUMNS(NUM_COLUMNS)) u_core (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_i             (cfg),
    .acc_i             (acc),
    .column_i          (column_i),
    .row_bits_i        (row_bits_i),
    .restore_pressed_i (restore_pressed_i),
    .adv_i             (adv),
    .s1_valid_o        (s1_valid),
    .result_o          (stage_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= stage_res;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign column_out_o     = out_q.column;
  assign stable_rows_o    = out_q.stable_rows;
  assign restore_stable_o = out_q.restore_stable;
  assign combo_active_o   = out_q.combo_active;
  assign combo_edge_o     = out_q.combo_edge;

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i && s1_valid)
    else $error("input stalled while the pipeline had room");

  a_output_from_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(adv))
    else $error("output became valid without a stage transfer");

  a_edge_on_last_column: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && combo_edge_o |-> {29'd0, column_out_o} == 32'(NUM_COLUMNS - 1))
    else $error("combo edge reported on a column other than the last");

endmodule
